// ===== rtl/dbpt_pkg.sv =====
// ============================================================================
// Path tokenizer package
// Shared constants, codes and record types of the dotted/bracket path
// tokenizer.
// ============================================================================
package dbpt_pkg;

    localparam int MAX_PATH_LEN = 4096;
    localparam int INDEX_WIDTH  = 64;
    localparam int POS_W        = $clog2(MAX_PATH_LEN + 1);
    localparam int OFFSET_W     = 12;
    localparam int LENGTH_W     = 13;
    localparam int INDEX_OUT_W  = 64;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [INDEX_WIDTH-1:0] INDEX_MAX   = '1;
    localparam logic [INDEX_WIDTH-1:0] INDEX_LIMIT =
        (INDEX_MAX - INDEX_WIDTH'(9)) / INDEX_WIDTH'(10);

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_RBR  = 8'h5D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        MODE_KEY,
        MODE_BRACKET,
        MODE_AFTER,
        MODE_ERROR
    } dbpt_mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_KEY    = 2'd0,
        KIND_INDEX  = 2'd1,
        KIND_STATUS = 2'd2
    } dbpt_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_BOUNDARY_DOT  = 3'd1,
        ST_OVERFLOW      = 3'd2,
        ST_EMPTY_INDEX   = 3'd3,
        ST_INVALID_INDEX = 3'd4,
        ST_JUNK          = 3'd5,
        ST_TOO_LONG      = 3'd6
    } dbpt_status_t;

    // One queue entry: the results caused by one byte, a step and/or a status.
    typedef struct packed {
        logic                   step_valid;
        dbpt_kind_t             step_kind;
        logic [OFFSET_W-1:0]    key_offset;
        logic [LENGTH_W-1:0]    key_length;
        logic [INDEX_WIDTH-1:0] index_value;
        logic                   status_valid;
        dbpt_status_t           status;
    } dbpt_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dbpt_qstat_t;

endpackage

// ===== rtl/dbpt_if.sv =====
// ============================================================================
// Path tokenizer channels
// Valid/ready channels for path bytes in and tokenizer results out.
// ============================================================================
interface dbpt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       is_final_byte;

    modport source (output valid, output path_byte, output is_final_byte, input ready);
    modport sink   (input valid, input path_byte, input is_final_byte, output ready);
endinterface

interface dbpt_step_if;
    import dbpt_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      step_kind;
    logic [OFFSET_W-1:0]    key_offset;
    logic [LENGTH_W-1:0]    key_length;
    logic [INDEX_OUT_W-1:0] index_value;
    logic [STATUS_W-1:0]    status;
    logic                   run_end;

    modport source (output valid, output step_kind, output key_offset, output key_length,
                    output index_value, output status, output run_end, input ready);
    modport sink   (input valid, input step_kind, input key_offset, input key_length,
                    input index_value, input status, input run_end, output ready);
endinterface

// ===== rtl/dbpt_front.sv =====
// ============================================================================
// Path tokenizer front end
// Classifies each path byte, updates the parse state and forms the queue
// entry that holds the results of that byte.
// ============================================================================
module dbpt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    input  logic                 in_final,
    output logic                 in_ready,
    input  dbpt_pkg::dbpt_qstat_t qstat,
    output logic                 push,
    output dbpt_pkg::dbpt_entry_t entry
);
    import dbpt_pkg::*;

    dbpt_mode_t             mode_reg, mode_next, mode_mid;
    logic                   after_reg, after_next, after_mid;
    logic [POS_W-1:0]       pos_reg, pos_next, pos_mid;
    logic [POS_W-1:0]       seg_reg, seg_next, seg_mid;
    logic [INDEX_WIDTH-1:0] acc_reg, acc_next, acc_mid;
    logic                   dig_reg, dig_next, dig_mid;
    dbpt_status_t           err_reg, err_next, err_mid;
    dbpt_status_t           fail_code;

    logic                   accept;
    logic                   is_dot, is_lbr, is_rbr, is_digit;
    logic                   boundary, active, too_long, proc, overflow;
    logic [INDEX_WIDTH-1:0] acc_mul;
    logic [POS_W-1:0]       byte_len, final_len;
    logic                   byte_key, index_step, final_key;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    // Byte classes.
    assign is_dot   = (in_byte == CH_DOT);
    assign is_lbr   = (in_byte == CH_LBR);
    assign is_rbr   = (in_byte == CH_RBR);
    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);

    assign boundary = in_final && is_dot;
    assign active   = !boundary && (mode_reg != MODE_ERROR);
    assign too_long = (pos_reg >= POS_W'(MAX_PATH_LEN));
    assign proc     = active && !too_long;
    assign overflow = (acc_reg > INDEX_LIMIT);
    assign acc_mul  = (acc_reg << 3) + (acc_reg << 1) + INDEX_WIDTH'(in_byte[3:0]);

    // Next state.
    always_comb
    begin
        mode_mid  = mode_reg;
        after_mid = after_reg;
        pos_mid   = pos_reg;
        seg_mid   = seg_reg;
        acc_mid   = acc_reg;
        dig_mid   = dig_reg;
        err_mid   = err_reg;
        fail_code = ST_OK;

        if (proc)
        begin
            pos_mid = pos_reg + POS_W'(1);
            unique case (mode_reg)
                MODE_KEY:
                begin
                    if (is_dot)
                    begin
                        if (pos_reg == '0)
                        begin
                            fail_code = ST_BOUNDARY_DOT;
                        end
                        else
                        begin
                            seg_mid   = pos_reg + POS_W'(1);
                            after_mid = 1'b1;
                        end
                    end
                    else if (is_lbr)
                    begin
                        after_mid = 1'b0;
                        mode_mid  = MODE_BRACKET;
                        acc_mid   = '0;
                        dig_mid   = 1'b0;
                    end
                end
                MODE_BRACKET:
                begin
                    if (is_digit)
                    begin
                        if (overflow)
                        begin
                            fail_code = ST_OVERFLOW;
                        end
                        else
                        begin
                            acc_mid = acc_mul;
                            dig_mid = 1'b1;
                        end
                    end
                    else if (is_rbr && dig_reg)
                    begin
                        mode_mid = MODE_AFTER;
                    end
                    else
                    begin
                        fail_code = dig_reg ? ST_INVALID_INDEX : ST_EMPTY_INDEX;
                    end
                end
                MODE_AFTER:
                begin
                    if (is_lbr)
                    begin
                        mode_mid = MODE_BRACKET;
                        acc_mid  = '0;
                        dig_mid  = 1'b0;
                    end
                    else if (is_dot)
                    begin
                        after_mid = 1'b1;
                        seg_mid   = pos_reg + POS_W'(1);
                        mode_mid  = MODE_KEY;
                    end
                    else
                    begin
                        fail_code = ST_JUNK;
                    end
                end
                default:
                begin
                    mode_mid = mode_reg;
                end
            endcase
        end
        else if (active && too_long)
        begin
            fail_code = ST_TOO_LONG;
        end

        // A path that ends inside brackets is an index error.
        if (in_final && active && (fail_code == ST_OK) && (mode_mid == MODE_BRACKET))
        begin
            fail_code = dig_mid ? ST_INVALID_INDEX : ST_EMPTY_INDEX;
        end

        if (fail_code != ST_OK)
        begin
            mode_mid = MODE_ERROR;
            err_mid  = fail_code;
        end

        // Every path starts from the reset state.
        if (in_final)
        begin
            mode_next  = MODE_KEY;
            after_next = 1'b0;
            pos_next   = '0;
            seg_next   = '0;
            acc_next   = '0;
            dig_next   = 1'b0;
            err_next   = ST_OK;
        end
        else
        begin
            mode_next  = mode_mid;
            after_next = after_mid;
            pos_next   = pos_mid;
            seg_next   = seg_mid;
            acc_next   = acc_mid;
            dig_next   = dig_mid;
            err_next   = err_mid;
        end
    end

    // Entry forming.
    always_comb
    begin
        byte_len   = pos_reg - seg_reg;
        final_len  = pos_mid - seg_mid;
        byte_key   = proc && (mode_reg == MODE_KEY)
                     && ((is_dot && (pos_reg != '0)) || is_lbr)
                     && ((byte_len != '0) || after_reg);
        index_step = proc && (mode_reg == MODE_BRACKET) && is_rbr && dig_reg;
        final_key  = in_final && !boundary && (mode_mid == MODE_KEY)
                     && ((final_len != '0) || after_mid);

        entry              = '0;
        entry.step_valid   = byte_key || index_step || final_key;
        entry.step_kind    = KIND_KEY;
        entry.status_valid = in_final;
        entry.status       = boundary ? ST_BOUNDARY_DOT : err_mid;

        if (index_step)
        begin
            entry.step_kind   = KIND_INDEX;
            entry.index_value = acc_reg;
        end
        else if (byte_key)
        begin
            entry.key_offset = OFFSET_W'(seg_reg);
            entry.key_length = LENGTH_W'(byte_len);
        end
        else if (final_key)
        begin
            entry.key_offset = OFFSET_W'(seg_mid);
            entry.key_length = LENGTH_W'(final_len);
        end

        push = accept && (entry.step_valid || entry.status_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_KEY;
            after_reg <= 1'b0;
            pos_reg   <= '0;
            seg_reg   <= '0;
            acc_reg   <= '0;
            dig_reg   <= 1'b0;
            err_reg   <= ST_OK;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            after_reg <= after_next;
            pos_reg   <= pos_next;
            seg_reg   <= seg_next;
            acc_reg   <= acc_next;
            dig_reg   <= dig_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== rtl/dbpt_queue.sv =====
// ============================================================================
// Path tokenizer entry queue
// Small first-in first-out queue between the front end and the back end.
// ============================================================================
module dbpt_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dbpt_pkg::dbpt_entry_t wr_entry,
    input  logic                  pop,
    output dbpt_pkg::dbpt_entry_t rd_entry,
    output dbpt_pkg::dbpt_qstat_t qstat
);
    import dbpt_pkg::*;

    dbpt_entry_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign rd_entry    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/dbpt_back.sv =====
// ============================================================================
// Path tokenizer back end
// Takes queue entries into an output register and presents the step and
// then the status of each entry as separate result transactions.
// ============================================================================
module dbpt_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dbpt_pkg::dbpt_entry_t rd_entry,
    input  dbpt_pkg::dbpt_qstat_t qstat,
    output logic                  pop,
    dbpt_step_if.source           out_step
);
    import dbpt_pkg::*;

    dbpt_entry_t cur_reg, cur_next;
    logic        step_pend_reg, step_pend_next;
    logic        stat_pend_reg, stat_pend_next;
    logic        out_fire, finishing, busy;

    assign busy      = step_pend_reg || stat_pend_reg;
    assign out_fire  = busy && out_step.ready;
    assign finishing = out_fire && !(step_pend_reg && stat_pend_reg);
    assign pop       = !qstat.empty && (!busy || finishing);

    always_comb
    begin
        cur_next       = cur_reg;
        step_pend_next = step_pend_reg;
        stat_pend_next = stat_pend_reg;
        if (pop)
        begin
            cur_next       = rd_entry;
            step_pend_next = rd_entry.step_valid;
            stat_pend_next = rd_entry.status_valid;
        end
        else if (finishing)
        begin
            step_pend_next = 1'b0;
            stat_pend_next = 1'b0;
        end
        else if (out_fire)
        begin
            // Step taken, its status follows.
            step_pend_next = 1'b0;
        end
    end

    always_comb
    begin
        out_step.valid       = busy;
        out_step.step_kind   = KIND_W'(KIND_STATUS);
        out_step.key_offset  = '0;
        out_step.key_length  = '0;
        out_step.index_value = '0;
        out_step.status      = STATUS_W'(cur_reg.status);
        out_step.run_end     = 1'b1;
        if (step_pend_reg)
        begin
            out_step.step_kind   = KIND_W'(cur_reg.step_kind);
            out_step.key_offset  = cur_reg.key_offset;
            out_step.key_length  = cur_reg.key_length;
            out_step.index_value = INDEX_OUT_W'(cur_reg.index_value);
            out_step.status      = STATUS_W'(ST_OK);
            out_step.run_end     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_pend_reg <= 1'b0;
            stat_pend_reg <= 1'b0;
        end
        else
        begin
            step_pend_reg <= step_pend_next;
            stat_pend_reg <= stat_pend_next;
        end
    end

endmodule

// ===== rtl/dotted_bracket_path_tokenizer.sv =====
// ============================================================================
// Dotted/bracket path tokenizer
// Splits path text such as "a.b[3].c" into key steps, index steps and a
// final status, one path byte per clock while its queue has room.
// ============================================================================
// The block takes one path byte per transaction on in_byte and, without any
// gap, can take a new byte on every clock while the queue is not full. A
// byte is classified and the parse state is updated in the same cycle it
// is accepted, so the only loop is that state update. The results of a
// byte (at most a key or index step plus, on the final byte, the end-of-path
// status) are written as one entry into a four-entry queue; the back end
// moves entries into its output register and presents each result as its
// own transaction on out_step. A result passes through the queue and the
// output register before it is presented. A byte that causes two results
// keeps the output busy for two transactions, and the queue absorbs that;
// in_byte.ready drops only when the queue is full. A status transaction
// carries run_end = 1 and closes the path; if its status is not ok, every
// step sent earlier for that path is void. After an error no further steps
// are sent for that path. An empty path sends nothing.
module dotted_bracket_path_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    dbpt_byte_if.sink   in_byte,
    dbpt_step_if.source out_step
);
    import dbpt_pkg::*;

    logic        q_push;
    logic        q_pop;
    dbpt_entry_t q_wr_entry;
    dbpt_entry_t q_rd_entry;
    dbpt_qstat_t q_stat;

    // Front end: classification and parse state.
    dbpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_byte.valid),
        .in_byte  (in_byte.path_byte),
        .in_final (in_byte.is_final_byte),
        .in_ready (in_byte.ready),
        .qstat    (q_stat),
        .push     (q_push),
        .entry    (q_wr_entry)
    );

    // Queue decoupling the two halves.
    dbpt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .qstat    (q_stat)
    );

    // Back end: result sequencing and output register.
    dbpt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_entry (q_rd_entry),
        .qstat    (q_stat),
        .pop      (q_pop),
        .out_step (out_step)
    );

    // The front end never writes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_stat.full))
        else $error("queue written while full");

    // A final byte always leaves a status entry behind.
    a_final_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_byte.valid && in_byte.ready && in_byte.is_final_byte) |=> !q_stat.empty)
        else $error("final byte left no entry");

    // Only status transactions close a path.
    a_run_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_step.valid |->
            (out_step.run_end == (out_step.step_kind == KIND_W'(KIND_STATUS))))
        else $error("run_end and step kind disagree");

    // The back end only takes an entry that is present.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("entry taken from empty queue");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Path tokenizer testbench
// Drives path text into the dotted/bracket path tokenizer one byte per
// transaction and checks every key step, index step and end-of-path status
// against a cycle-free model of the parser kept inside this bench. A short
// table of hand-picked paths, including the longest legal path, comes
// first; seeded random paths, mostly well formed, follow in three phases
// with different amounts of idling on each side.
// ============================================================================
module tb_top;
    import dbpt_pkg::*;

    // Run sizing. Results only pass the queue and the output register, so a short
    // settle window after the last expected result is enough to catch strays.
    localparam int RANDOM_BYTES_PER_PHASE = 540;
    localparam int HOLD_CYCLES            = 80;
    localparam int DRAIN_LIMIT            = 20000;
    localparam int SETTLE_CYCLES          = 20;

    typedef logic [7:0] path_q_t[$];

    // One result transaction as the tokenizer should present it.
    typedef struct {
        dbpt_kind_t             kind;
        logic [OFFSET_W-1:0]    offset;
        logic [LENGTH_W-1:0]    length;
        logic [INDEX_OUT_W-1:0] index;
        dbpt_status_t           status;
        logic                   run_end;
    } step_rec_t;

    // One row of the directed table. A row may start with a run of filler
    // key bytes so that the table can reach the length limit. Where typed is
    // set, the closing status is taken from the row instead of the model.
    typedef struct {
        string        text;
        int           fill;
        bit           typed;
        dbpt_status_t status;
    } path_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dbpt_byte_if byte_ch ();
    dbpt_step_if step_ch ();

    dotted_bracket_path_tokenizer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (byte_ch),
        .out_step (step_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Directed table. The long rows sit at the end: exactly the maximum path
    // length in one key, a key that starts at the last legal position, and a
    // path one byte over the limit.
    // ------------------------------------------------------------------------
    path_row_t dir_rows[$] = '{
        '{"a",                      0,    1'b0, ST_OK},
        '{".",                      0,    1'b1, ST_BOUNDARY_DOT},
        '{".a",                     0,    1'b1, ST_BOUNDARY_DOT},
        '{"a..b",                   0,    1'b0, ST_OK},
        '{"ab.c[12][0].d",          0,    1'b0, ST_OK},
        '{"\377\200.\001",          0,    1'b0, ST_OK},
        '{"[",                      0,    1'b1, ST_EMPTY_INDEX},
        '{"k[",                     0,    1'b1, ST_EMPTY_INDEX},
        '{"[]x",                    0,    1'b1, ST_EMPTY_INDEX},
        '{"[7y]",                   0,    1'b1, ST_INVALID_INDEX},
        '{"[42",                    0,    1'b1, ST_INVALID_INDEX},
        '{"[1]z",                   0,    1'b1, ST_JUNK},
        '{"a.[",                    0,    1'b1, ST_EMPTY_INDEX},
        '{"x[3].",                  0,    1'b1, ST_BOUNDARY_DOT},
        '{"[18446744073709551609]", 0,    1'b0, ST_OK},
        '{"[18446744073709551610]", 0,    1'b1, ST_OVERFLOW},
        '{"",                       4096, 1'b0, ST_OK},
        '{".b",                     4094, 1'b0, ST_OK},
        '{"q",                      4096, 1'b1, ST_TOO_LONG}
    };

    // ------------------------------------------------------------------------
    // Parser model state, a private copy of what the tokenizer tracks.
    // ------------------------------------------------------------------------
    dbpt_mode_t         tk_mode;
    logic               tk_after_dot;
    int unsigned        tk_pos;
    int unsigned        tk_seg_start;
    logic [63:0]        tk_acc;
    logic               tk_digit_seen;
    dbpt_status_t       tk_error;

    // Results still owed by the tokenizer, oldest first.
    step_rec_t          pending_steps[$];

    // Closing status supplied by a directed row.
    bit                 typed_on;
    dbpt_status_t       typed_code;

    // Idling percentages for each side and the long receiver hold-off.
    int                 src_idle_pct;
    int                 sink_idle_pct;
    bit                 hold_req;

    int                 mismatches;
    int                 paths_sent;
    int                 bytes_sent;
    int                 results_checked;
    int                 kind_count[3];
    int                 status_count[8];
    int                 input_stalls;

    function automatic void push_step(input dbpt_kind_t kind, input int unsigned off,
                                      input int unsigned len, input logic [63:0] idx,
                                      input dbpt_status_t st, input logic last);
        step_rec_t r;
        r.kind    = kind;
        r.offset  = OFFSET_W'(off);
        r.length  = LENGTH_W'(len);
        r.index   = idx;
        r.status  = st;
        r.run_end = last;
        pending_steps.push_back(r);
    endfunction

    function automatic void reset_tokenizer();
        tk_mode       = MODE_KEY;
        tk_after_dot  = 1'b0;
        tk_pos        = 0;
        tk_seg_start  = 0;
        tk_acc        = '0;
        tk_digit_seen = 1'b0;
        tk_error      = ST_OK;
    endfunction

    // Only the first error of a path is reported; the mode sticks until the
    // final byte.
    function automatic void note_error(input dbpt_status_t code);
        if (tk_error == ST_OK)
            tk_error = code;
        tk_mode = MODE_ERROR;
    endfunction

    // A key ending at endpos is reported when it has bytes, or when a dot led
    // into it so that an empty key between two dots still counts.
    function automatic void close_key(input int unsigned endpos);
        int unsigned len;
        len = endpos - tk_seg_start;
        if (len > 0 || tk_after_dot)
            push_step(KIND_KEY, tk_seg_start, len, '0, ST_OK, 1'b0);
        tk_after_dot = 1'b0;
    endfunction

    // Works out the results of one accepted byte and queues them.
    function automatic void predict_byte(input logic [7:0] b, input logic fin);
        dbpt_status_t st;
        // A closing dot wins over everything else and sends no step.
        if (fin && b == CH_DOT)
        begin
            push_step(KIND_STATUS, 0, 0, '0, typed_on ? typed_code : ST_BOUNDARY_DOT, 1'b1);
            reset_tokenizer();
            return;
        end
        if (tk_mode != MODE_ERROR)
        begin
            if (tk_pos >= MAX_PATH_LEN)
            begin
                note_error(ST_TOO_LONG);
            end
            else
            begin
                case (tk_mode)
                    MODE_KEY:
                    begin
                        if (b == CH_DOT)
                        begin
                            if (tk_pos == 0)
                            begin
                                note_error(ST_BOUNDARY_DOT);
                            end
                            else
                            begin
                                close_key(tk_pos);
                                tk_after_dot = 1'b1;
                                tk_seg_start = tk_pos + 1;
                            end
                        end
                        else if (b == CH_LBR)
                        begin
                            close_key(tk_pos);
                            tk_mode       = MODE_BRACKET;
                            tk_acc        = '0;
                            tk_digit_seen = 1'b0;
                        end
                    end
                    MODE_BRACKET:
                    begin
                        if (b >= CH_ZERO && b <= CH_NINE)
                        begin
                            if (tk_acc > INDEX_LIMIT)
                            begin
                                note_error(ST_OVERFLOW);
                            end
                            else
                            begin
                                tk_acc        = tk_acc * 64'd10 + 64'(b - CH_ZERO);
                                tk_digit_seen = 1'b1;
                            end
                        end
                        else if (b == CH_RBR && tk_digit_seen)
                        begin
                            push_step(KIND_INDEX, 0, 0, tk_acc, ST_OK, 1'b0);
                            tk_mode = MODE_AFTER;
                        end
                        else
                        begin
                            note_error(tk_digit_seen ? ST_INVALID_INDEX : ST_EMPTY_INDEX);
                        end
                    end
                    default:
                    begin
                        if (b == CH_LBR)
                        begin
                            tk_mode       = MODE_BRACKET;
                            tk_acc        = '0;
                            tk_digit_seen = 1'b0;
                        end
                        else if (b == CH_DOT)
                        begin
                            tk_after_dot = 1'b1;
                            tk_seg_start = tk_pos + 1;
                            tk_mode      = MODE_KEY;
                        end
                        else
                        begin
                            note_error(ST_JUNK);
                        end
                    end
                endcase
                tk_pos = tk_pos + 1;
            end
            // The final byte closes an open key, or fails an open bracket.
            if (fin && tk_mode != MODE_ERROR)
            begin
                if (tk_mode == MODE_KEY)
                    close_key(tk_pos);
                else if (tk_mode == MODE_BRACKET)
                    note_error(tk_digit_seen ? ST_INVALID_INDEX : ST_EMPTY_INDEX);
            end
        end
        if (fin)
        begin
            st = typed_on ? typed_code : tk_error;
            push_step(KIND_STATUS, 0, 0, '0, st, 1'b1);
            reset_tokenizer();
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard. Outputs and inputs are both sampled at the rising edge. The
    // output side is handled before the byte accepted at the same edge is
    // modeled, so a result can only ever be matched against older bytes.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        step_rec_t want;
        if (rst_n)
        begin
            if (step_ch.valid && step_ch.ready)
            begin
                if (pending_steps.size() == 0)
                begin
                    $display("%0t: result with nothing expected: %s kind %0d status %0d",
                             $time, "expected none, actual", step_ch.step_kind,
                             step_ch.status);
                    mismatches++;
                end
                else
                begin
                    want = pending_steps.pop_front();
                    check_field("step_kind",   want.kind,    step_ch.step_kind);
                    check_field("key_offset",  want.offset,  step_ch.key_offset);
                    check_field("key_length",  want.length,  step_ch.key_length);
                    check_field("index_value", want.index,   step_ch.index_value);
                    check_field("status",      want.status,  step_ch.status);
                    check_field("run_end",     want.run_end, step_ch.run_end);
                    results_checked++;
                    kind_count[want.kind]++;
                    if (want.kind == KIND_STATUS)
                        status_count[want.status]++;
                end
            end
            if (byte_ch.valid && byte_ch.ready)
                predict_byte(byte_ch.path_byte, byte_ch.is_final_byte);
            if (byte_ch.valid && !byte_ch.ready)
                input_stalls++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Ready changes only at the falling edge. A hold request from
    // the main flow keeps ready low for a long stretch, counted here, while
    // the sender keeps offering bytes so the internal queue fills up.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        step_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                step_ch.ready <= 1'b0;
            end
            else
            begin
                step_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offers one byte, starting at a falling edge, and returns at the falling
    // edge after it was taken. Idle cycles come before the byte, so valid
    // never drops and rises again within one time step.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.path_byte     <= b;
        byte_ch.is_final_byte <= fin;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_path(input path_q_t p);
        for (int i = 0; i < p.size(); i++)
            send_byte(p[i], i == p.size() - 1);
        paths_sent++;
        bytes_sent += p.size();
    endtask

    // Lets the tokenizer catch up until every queued result has been seen,
    // with a bound so that a stuck block still reaches the final report. The
    // sender drops valid first so that the last byte is not offered again.
    task automatic drain_expected();
        int waited;
        waited = 0;
        byte_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_steps.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
    endtask

    // A random path: up to four segments, each a short key of arbitrary
    // bytes and up to two bracket indexes, now and then with 18 to 20 digits
    // so that large values and overflow both occur. About a quarter of the
    // paths are then broken on purpose.
    function automatic path_q_t random_path();
        path_q_t     p;
        int          nseg;
        int          nidx;
        int          ndig;
        logic [7:0]  b;
        nseg = $urandom_range(1, 4);
        for (int s = 0; s < nseg; s++)
        begin
            if (s > 0)
                p.push_back(CH_DOT);
            repeat ($urandom_range(0, 5))
            begin
                if ($urandom_range(1))
                    b = 8'($urandom_range(8'h61, 8'h7A));
                else
                    b = 8'($urandom_range(255));
                if (b == CH_DOT || b == CH_LBR)
                    b = "_";
                p.push_back(b);
            end
            nidx = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
            repeat (nidx)
            begin
                p.push_back(CH_LBR);
                ndig = ($urandom_range(7) == 0) ? $urandom_range(18, 20) : $urandom_range(1, 3);
                repeat (ndig)
                    p.push_back(CH_ZERO + 8'($urandom_range(9)));
                p.push_back(CH_RBR);
            end
        end
        if ($urandom_range(99) < 25)
        begin
            case ($urandom_range(3))
                0: if (p.size() > 0) p[$urandom_range(p.size() - 1)] = 8'($urandom_range(255));
                1: if (p.size() > 1) p = p[0:$urandom_range(p.size() - 2)];
                2: p.push_back(CH_DOT);
                default: p.push_front(CH_DOT);
            endcase
        end
        if (p.size() == 0)
            p.push_back(8'($urandom_range(255)));
        return p;
    endfunction

    // One random phase. Every eighth path the sender waits until all
    // results are back; with hold_once set, the receiver is held off once
    // early in the phase while bytes keep coming.
    task automatic random_phase(input int src_pct, input int sink_pct, input bit hold_once);
        path_q_t p;
        int      phase_bytes;
        int      phase_paths;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        phase_bytes   = 0;
        phase_paths   = 0;
        while (phase_bytes < RANDOM_BYTES_PER_PHASE)
        begin
            if (hold_once && phase_paths == 4)
                hold_req = 1'b1;
            p = random_path();
            send_path(p);
            phase_bytes += p.size();
            phase_paths++;
            if (phase_paths % 8 == 0)
                drain_expected();
        end
        drain_expected();
    endtask

    // ------------------------------------------------------------------------
    // Main flow: reset, directed table, three random phases, final report.
    // ------------------------------------------------------------------------
    initial
    begin
        path_q_t p;
        byte_ch.valid         <= 1'b0;
        byte_ch.path_byte     <= '0;
        byte_ch.is_final_byte <= 1'b0;
        hold_req      = 1'b0;
        typed_on      = 1'b0;
        typed_code    = ST_OK;
        src_idle_pct  = 12;
        sink_idle_pct = 45;
        reset_tokenizer();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows run with the sender idling lightly and the receiver
        // heavily. The typed status is only consulted on the final byte.
        foreach (dir_rows[i])
        begin
            p = {};
            repeat (dir_rows[i].fill)
                p.push_back("z");
            for (int j = 0; j < dir_rows[i].text.len(); j++)
                p.push_back(dir_rows[i].text[j]);
            typed_on   = dir_rows[i].typed;
            typed_code = dir_rows[i].status;
            send_path(p);
            typed_on   = 1'b0;
        end
        drain_expected();

        random_phase(12, 45, 1'b1);
        random_phase(45, 12, 1'b0);
        random_phase(0, 0, 1'b1);

        drain_expected();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_steps.size() != 0)
        begin
            $display("%0t: expected %0d more results, actual none arrived",
                     $time, pending_steps.size());
            mismatches += pending_steps.size();
        end

        $display("Tokenized %0d paths (%0d bytes): %0d results checked, %s",
                 paths_sent, bytes_sent, results_checked, "split as follows.");
        $display("  %0d key / %0d index / %0d status, input stalled %0d cycles.",
                 kind_count[KIND_KEY], kind_count[KIND_INDEX], kind_count[KIND_STATUS],
                 input_stalls);
        $display("Closing status mix: ok %0d, dot %0d, overflow %0d, empty %0d,",
                 status_count[ST_OK], status_count[ST_BOUNDARY_DOT],
                 status_count[ST_OVERFLOW], status_count[ST_EMPTY_INDEX]);
        $display("  invalid %0d, junk %0d, too long %0d.",
                 status_count[ST_INVALID_INDEX], status_count[ST_JUNK],
                 status_count[ST_TOO_LONG]);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
